FILE: src/aoma_pkg.sv
`default_nettype none

package aoma_pkg;

  localparam int SAMPLE_BITS = 12;
  localparam int CHAN_W      = 2;
  localparam int CHAN_NUM    = 4;
  localparam int VAL_W       = 14;
  localparam int ACC_W       = 32;
  localparam int OS_DIVISOR  = 4;
  localparam int OS_SHIFT    = $clog2(OS_DIVISOR);

  localparam logic [VAL_W-1:0] VAL_MAX = '1;

  typedef logic [CHAN_W-1:0]      chan_t;
  typedef logic [SAMPLE_BITS-1:0] sample_t;
  typedef logic [VAL_W-1:0]       val_t;
  typedef logic [ACC_W-1:0]       acc_t;

endpackage

`default_nettype wire

FILE: src/aoma_if.sv
`default_nettype none

interface aoma_in_if;
  import aoma_pkg::*;

  logic    valid;
  logic    ready;
  chan_t   chan;
  sample_t sample;
  logic    scan_end;

  modport source (output valid, chan, sample, scan_end, input ready);
  modport sink (input valid, chan, sample, scan_end, output ready);
endinterface

interface aoma_out_if;
  import aoma_pkg::*;

  logic  valid;
  logic  ready;
  chan_t chan_out;
  val_t  oversampled_value;
  val_t  averaged_value;
  logic  decimated;
  logic  window_full;

  modport source (output valid, chan_out, oversampled_value, averaged_value, decimated,
                  window_full, input ready);
  modport sink (input valid, chan_out, oversampled_value, averaged_value, decimated,
                window_full, output ready);
endinterface

`default_nettype wire

FILE: src/aoma_win_div.sv
`default_nettype none

module aoma_win_div #(
  parameter int WINDOW = 30,
  parameter int SUM_W  = 19
) (
  input  logic [SUM_W-1:0] sum,
  output aoma_pkg::val_t   quot
);
  import aoma_pkg::*;

  // exact floor division by reciprocal multiply for sums below WINDOW * 2**VAL_W
  localparam int SHIFT   = SUM_W + $clog2(WINDOW);
  localparam int RECIP_W = SUM_W + 2;
  localparam int PROD_W  = SUM_W + RECIP_W;
  localparam longint unsigned RECIP64 =
    ((64'd1 << SHIFT) + 64'(WINDOW) - 64'd1) / 64'(WINDOW);
  localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(RECIP64);

  logic [PROD_W-1:0] prod;

  assign prod = PROD_W'(sum) * PROD_W'(RECIP);
  assign quot = prod[SHIFT +: VAL_W];

endmodule

`default_nettype wire

FILE: src/adc_oversample_moving_average.sv
// an accepted request passes the stage 1, stage 2 and output registers
// throughput: one request per cycle unless stalled, set by the read-modify-write
//   of the channel store and window ring with write-to-read forwarding
// a stalled output holds the whole pipeline; input ready follows output space
// reset: synchronous active low; clears control state and the valid bits of the
//   channel store and the window ring, so unwritten entries read as zero
`default_nettype none

module adc_oversample_moving_average #(
  parameter int WINDOW           = 30,
  parameter int OVERSAMPLE_COUNT = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic        cfg_wdata,
  aoma_in_if.sink     in_req,
  aoma_out_if.source  out_req
);
  import aoma_pkg::*;

  localparam int SUM_W      = VAL_W + $clog2(WINDOW);
  localparam int POS_W      = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int CNT_W      = (OVERSAMPLE_COUNT > 1) ? $clog2(OVERSAMPLE_COUNT) : 1;
  localparam int RADDR_W    = CHAN_W + POS_W;
  localparam int RING_DEPTH = 1 << RADDR_W;
  localparam int OV_W       = ACC_W - OS_SHIFT;

  // control
  logic             enable_r, enable_nxt;
  logic [CNT_W-1:0] scan_cnt_r, scan_cnt_nxt;
  logic [POS_W-1:0] ring_pos_r, ring_pos_nxt;
  logic             filled_r, filled_nxt;

  // stores
  acc_t             acc_mem_r  [CHAN_NUM];
  val_t             ov_mem_r   [CHAN_NUM];
  logic [SUM_W-1:0] wsum_mem_r [CHAN_NUM];
  val_t             ring_mem_r [RING_DEPTH];
  logic [CHAN_NUM-1:0]   cvld_r;
  logic [RING_DEPTH-1:0] rvld_r;

  // stage 1
  logic             s1_valid_r;
  chan_t            s1_chan_r;
  sample_t          s1_sample_r;
  logic             s1_en_r;
  logic             s1_dscan_r;
  logic [POS_W-1:0] s1_pos_r;
  logic             s1_full_r;
  acc_t             rd_acc_r;
  val_t             rd_ov_r;
  logic [SUM_W-1:0] rd_wsum_r;
  logic             rd_cvld_r;
  val_t             rd_ring_r;
  logic             rd_rvld_r;

  // stage 2
  logic             s2_valid_r;
  chan_t            s2_chan_r;
  val_t             s2_ov_r;
  logic [SUM_W-1:0] s2_wsum_r;
  logic             s2_dec_r;
  logic             s2_full_r;

  // output register
  logic  out_valid_r;
  chan_t out_chan_r;
  val_t  out_ov_r;
  val_t  out_avg_r;
  logic  out_dec_r;
  logic  out_full_r;

  logic               adv, acc_in, dscan, pos_wrap;
  logic [RADDR_W-1:0] raddr, waddr;
  acc_t               old_acc, acc_sum, new_acc;
  val_t               old_ov, old_ring, ov_sat, new_ov;
  logic [SUM_W-1:0]   old_wsum, new_wsum;
  logic [OV_W-1:0]    ov_wide;
  logic               s1_dec, wr_c, wr_r, hit_c, hit_r;
  val_t               avg_q;

  assign adv          = !out_valid_r || out_req.ready;
  assign acc_in       = in_req.valid && adv;
  assign in_req.ready = adv;

  assign dscan    = (scan_cnt_r == CNT_W'(OVERSAMPLE_COUNT - 1));
  assign pos_wrap = (ring_pos_r == POS_W'(WINDOW - 1));

  always_comb begin
    enable_nxt   = cfg_we ? cfg_wdata : enable_r;
    scan_cnt_nxt = scan_cnt_r;
    ring_pos_nxt = ring_pos_r;
    filled_nxt   = filled_r;
    if (acc_in && enable_r && in_req.scan_end) begin
      if (dscan) begin
        scan_cnt_nxt = '0;
        ring_pos_nxt = pos_wrap ? '0 : ring_pos_r + POS_W'(1);
        filled_nxt   = filled_r | pos_wrap;
      end else begin
        scan_cnt_nxt = scan_cnt_r + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enable_r   <= 1'b0;
      scan_cnt_r <= '0;
      ring_pos_r <= '0;
      filled_r   <= 1'b0;
    end else begin
      enable_r   <= enable_nxt;
      scan_cnt_r <= scan_cnt_nxt;
      ring_pos_r <= ring_pos_nxt;
      filled_r   <= filled_nxt;
    end
  end

  // read-modify-write of the channel record and ring entry
  always_comb begin
    old_acc  = rd_cvld_r ? rd_acc_r : '0;
    old_ov   = rd_cvld_r ? rd_ov_r : '0;
    old_wsum = rd_cvld_r ? rd_wsum_r : '0;
    old_ring = rd_rvld_r ? rd_ring_r : '0;
    acc_sum  = old_acc + ACC_W'(s1_sample_r);
    ov_wide  = acc_sum[ACC_W-1:OS_SHIFT];
    ov_sat   = (ov_wide > OV_W'(VAL_MAX)) ? VAL_MAX : ov_wide[VAL_W-1:0];
    s1_dec   = s1_en_r && s1_dscan_r;
    new_acc  = s1_en_r ? (s1_dec ? '0 : acc_sum) : old_acc;
    new_ov   = s1_dec ? ov_sat : old_ov;
    new_wsum = s1_dec ? (old_wsum - SUM_W'(old_ring) + SUM_W'(ov_sat)) : old_wsum;
  end

  assign wr_c  = s1_valid_r && s1_en_r;
  assign wr_r  = s1_valid_r && s1_dec;
  assign raddr = {in_req.chan, ring_pos_r};
  assign waddr = {s1_chan_r, s1_pos_r};
  assign hit_c = wr_c && (s1_chan_r == in_req.chan);
  assign hit_r = wr_r && (waddr == raddr);

  always_ff @(posedge clk) begin
    if (adv && wr_c) begin
      acc_mem_r[s1_chan_r]  <= new_acc;
      ov_mem_r[s1_chan_r]   <= new_ov;
      wsum_mem_r[s1_chan_r] <= new_wsum;
    end
    if (adv && wr_r) begin
      ring_mem_r[waddr] <= ov_sat;
    end
    if (adv) begin
      // forward the write of this edge to the read issued at it
      rd_acc_r  <= hit_c ? new_acc : acc_mem_r[in_req.chan];
      rd_ov_r   <= hit_c ? new_ov : ov_mem_r[in_req.chan];
      rd_wsum_r <= hit_c ? new_wsum : wsum_mem_r[in_req.chan];
      rd_cvld_r <= hit_c | cvld_r[in_req.chan];
      rd_ring_r <= hit_r ? ov_sat : ring_mem_r[raddr];
      rd_rvld_r <= hit_r | rvld_r[raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cvld_r <= '0;
      rvld_r <= '0;
    end else if (adv) begin
      if (wr_c) begin
        cvld_r[s1_chan_r] <= 1'b1;
      end
      if (wr_r) begin
        rvld_r[waddr] <= 1'b1;
      end
    end
  end

  // pipeline payload
  always_ff @(posedge clk) begin
    if (adv) begin
      s1_chan_r   <= in_req.chan;
      s1_sample_r <= in_req.sample;
      s1_en_r     <= enable_r;
      s1_dscan_r  <= dscan;
      s1_pos_r    <= ring_pos_r;
      s1_full_r   <= filled_nxt;
      s2_chan_r   <= s1_chan_r;
      s2_ov_r     <= new_ov;
      s2_wsum_r   <= new_wsum;
      s2_dec_r    <= s1_dec;
      s2_full_r   <= s1_full_r;
      out_chan_r  <= s2_chan_r;
      out_ov_r    <= s2_ov_r;
      out_avg_r   <= avg_q;
      out_dec_r   <= s2_dec_r;
      out_full_r  <= s2_full_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      s2_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      s1_valid_r  <= acc_in;
      s2_valid_r  <= s1_valid_r;
      out_valid_r <= s2_valid_r;
    end
  end

  aoma_win_div #(
    .WINDOW (WINDOW),
    .SUM_W  (SUM_W)
  ) u_win_div (
    .sum  (s2_wsum_r),
    .quot (avg_q)
  );

  assign out_req.valid             = out_valid_r;
  assign out_req.chan_out          = out_chan_r;
  assign out_req.oversampled_value = out_ov_r;
  assign out_req.averaged_value    = out_avg_r;
  assign out_req.decimated         = out_dec_r;
  assign out_req.window_full       = out_full_r;

`ifndef ASSERT_OFF
  a_pos_bound: assert property (@(posedge clk) disable iff (!rst_n)
    ring_pos_r <= POS_W'(WINDOW - 1))
    else $error("ring position beyond window");

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    scan_cnt_r <= CNT_W'(OVERSAMPLE_COUNT - 1))
    else $error("scan count beyond oversample count");

  a_full_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    filled_r |=> filled_r)
    else $error("window full flag dropped");

  a_ring_wr_chan_wr: assert property (@(posedge clk) disable iff (!rst_n)
    wr_r |-> wr_c)
    else $error("ring written without channel record update");
`endif

endmodule

`default_nettype wire

FILE: tb/sv/adc_oversample_moving_average_tb.sv
`timescale 1ns / 100ps

module adc_oversample_moving_average_tb;
  import aoma_pkg::*;

  localparam int AVG_WINDOW  = 30;
  localparam int DEC_SCANS   = 16;
  localparam int PHASE_ITEMS = 360;

  typedef struct packed {
    chan_t chan;
    val_t  oversampled;
    val_t  averaged;
    logic  decimated;
    logic  window_full;
  } avg_result_t;

  class oversample_tracker;
    bit          enable;
    acc_t        scan_sum [CHAN_NUM];
    val_t        os_val   [CHAN_NUM];
    val_t        avg_val  [CHAN_NUM];
    val_t        ring     [CHAN_NUM][AVG_WINDOW];
    int unsigned win_sum  [CHAN_NUM];
    int unsigned scan_idx;
    int unsigned ring_pos;
    bit          filled;
    avg_result_t pending_results[$];
    int          mismatches;

    function new();
      enable = 1'b0;
      foreach (scan_sum[c]) begin
        scan_sum[c] = '0;
        os_val[c]   = '0;
        avg_val[c]  = '0;
        win_sum[c]  = 0;
      end
      foreach (ring[c, w]) ring[c][w] = '0;
      scan_idx   = 0;
      ring_pos   = 0;
      filled     = 1'b0;
      mismatches = 0;
    endfunction

    function void absorb_sample(chan_t ch, sample_t smp, logic last);
      avg_result_t r;
      bit          dec_scan;
      int unsigned ov;
      int unsigned pos;
      r.decimated = 1'b0;
      if (enable) begin
        dec_scan = scan_idx >= DEC_SCANS - 1;
        scan_sum[ch] += smp;
        if (dec_scan) begin
          ov = scan_sum[ch] / OS_DIVISOR;
          if (ov > VAL_MAX) ov = VAL_MAX;
          pos = ring_pos % AVG_WINDOW;
          scan_sum[ch] = '0;
          os_val[ch] = val_t'(ov);
          win_sum[ch] = win_sum[ch] - ring[ch][pos] + ov;
          ring[ch][pos] = val_t'(ov);
          avg_val[ch] = val_t'(win_sum[ch] / AVG_WINDOW);
          r.decimated = 1'b1;
        end
        if (last) begin
          if (dec_scan) begin
            scan_idx = 0;
            ring_pos++;
            if (ring_pos >= AVG_WINDOW) begin
              ring_pos = 0;
              filled = 1'b1;
            end
          end else begin
            scan_idx++;
          end
        end
      end
      r.chan        = ch;
      r.oversampled = os_val[ch];
      r.averaged    = avg_val[ch];
      r.window_full = filled;
      pending_results.push_back(r);
    endfunction

    function void note_failure(string what, avg_result_t want, avg_result_t got);
      string exp_s;
      string got_s;
      mismatches++;
      if (mismatches <= 10) begin
        exp_s = $sformatf("chan %0d os %0d avg %0d dec %0b full %0b", want.chan,
                          want.oversampled, want.averaged, want.decimated, want.window_full);
        got_s = $sformatf("chan %0d os %0d avg %0d dec %0b full %0b", got.chan,
                          got.oversampled, got.averaged, got.decimated, got.window_full);
        $display("%s: expected %s; got %s", what, exp_s, got_s);
      end
    endfunction

    function void check_result(avg_result_t got);
      avg_result_t want;
      if (pending_results.size() == 0) begin
        note_failure("result with no request pending", '0, got);
        return;
      end
      want = pending_results.pop_front();
      if (got.chan !== want.chan || got.oversampled !== want.oversampled ||
          got.averaged !== want.averaged || got.decimated !== want.decimated ||
          got.window_full !== want.window_full)
        note_failure("result mismatch", want, got);
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n;
  logic cfg_we;
  logic cfg_wdata;

  aoma_in_if  in_bus ();
  aoma_out_if out_bus ();

  oversample_tracker tracker;
  int send_idle_pct;
  int recv_stall_pct;
  int ready_hold;
  bit max_samples;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  adc_oversample_moving_average #(
    .WINDOW           (AVG_WINDOW),
    .OVERSAMPLE_COUNT (DEC_SCANS)
  ) u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_req    (in_bus),
    .out_req   (out_bus)
  );

  always @(posedge clk) begin
    if (out_bus.valid && out_bus.ready)
      tracker.check_result(avg_result_t'{out_bus.chan_out, out_bus.oversampled_value,
                                         out_bus.averaged_value, out_bus.decimated,
                                         out_bus.window_full});
    if (!rst_n) begin
      out_bus.ready <= 1'b0;
    end else if (ready_hold > 0) begin
      out_bus.ready <= 1'b0;
      ready_hold--;
    end else begin
      out_bus.ready <= $urandom_range(0, 99) >= recv_stall_pct;
    end
  end

  function automatic sample_t pick_sample();
    if (max_samples) return '1;
    case ($urandom_range(0, 9))
      0: return '0;
      1: return '1;
      default: return sample_t'($urandom_range(0, (1 << SAMPLE_BITS) - 1));
    endcase
  endfunction

  task automatic send_req(chan_t ch, sample_t smp, logic last);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_bus.valid <= 1'b0;
      @(posedge clk);
    end
    in_bus.valid    <= 1'b1;
    in_bus.chan     <= ch;
    in_bus.sample   <= smp;
    in_bus.scan_end <= last;
    @(posedge clk);
    while (!in_bus.ready) @(posedge clk);
    tracker.absorb_sample(ch, smp, last);
  endtask

  task automatic settle();
    in_bus.valid <= 1'b0;
    while (tracker.pending_results.size() > 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_enable(bit v);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    tracker.enable = v;
  endtask

  // mostly ordered scans with random content, some shuffled or repeated
  // channels, some broken scans with random scan_end marks
  task automatic run_scans(int n_items);
    int done;
    int kind;
    int len;
    chan_t ch;
    done = 0;
    while (done < n_items) begin
      kind = $urandom_range(0, 99);
      len  = $urandom_range(1, 4);
      for (int i = 0; i < len; i++) begin
        if (kind < 70) ch = chan_t'(i);
        else ch = chan_t'($urandom_range(0, CHAN_NUM - 1));
        send_req(ch, pick_sample(),
                 (kind < 92) ? (i == len - 1) : 1'($urandom_range(0, 1)));
      end
      done += len;
    end
  endtask

  initial begin
    #1000000;
    $display("[FAIL] regression broken");
    $finish;
  end

  initial begin
    tracker         = new();
    rst_n           = 1'b0;
    cfg_we          = 1'b0;
    cfg_wdata       = 1'b0;
    in_bus.valid    = 1'b0;
    in_bus.chan     = '0;
    in_bus.sample   = '0;
    in_bus.scan_end = 1'b0;
    out_bus.ready   = 1'b0;
    send_idle_pct   = 0;
    recv_stall_pct  = 0;
    ready_hold      = 0;
    max_samples     = 1'b0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // disabled after reset: nothing counts
    send_req(2'd0, 12'hFFF, 1'b0);
    send_req(2'd3, 12'h000, 1'b1);
    send_req(2'd1, 12'h555, 1'b1);
    settle();
    write_enable(1'b1);
    send_req(2'd0, 12'hFFF, 1'b0);
    send_req(2'd1, 12'h000, 1'b0);
    send_req(2'd2, 12'hAAA, 1'b0);
    send_req(2'd3, 12'h555, 1'b1);
    // repeated channel
    send_req(2'd2, 12'hFFF, 1'b0);
    send_req(2'd2, 12'h001, 1'b0);
    send_req(2'd0, 12'h800, 1'b1);
    // missing channels
    send_req(2'd1, 12'h7FF, 1'b1);
    send_req(2'd3, 12'hFFF, 1'b0);
    send_req(2'd3, 12'h000, 1'b1);
    settle();

    for (int p = 0; p < 4; p++) begin
      case (p)
        0: begin
          send_idle_pct  = 0;
          recv_stall_pct = 0;
        end
        1: begin
          send_idle_pct  = 75;
          recv_stall_pct = 0;
        end
        2: begin
          send_idle_pct  = 0;
          recv_stall_pct = 75;
        end
        default: begin
          send_idle_pct  = 35;
          recv_stall_pct = 35;
        end
      endcase
      if (p == 0) begin
        ready_hold  = 300;
        max_samples = 1'b1;
        run_scans(120);
        max_samples = 1'b0;
        run_scans(PHASE_ITEMS - 120);
      end else if (p == 1) begin
        run_scans(PHASE_ITEMS / 2);
        settle();
        run_scans(PHASE_ITEMS / 2);
      end else begin
        run_scans(PHASE_ITEMS);
      end
      settle();
      write_enable(1'b0);
      run_scans(12);
      settle();
      if (p < 3) write_enable(1'b1);
    end

    settle();
    if (tracker.mismatches == 0 && tracker.pending_results.size() == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

endmodule

FILE: files.f
src/aoma_pkg.sv
src/aoma_if.sv
src/aoma_win_div.sv
src/adc_oversample_moving_average.sv
tb/sv/adc_oversample_moving_average_tb.sv
